### design/tccw_pkg.sv
// ============================================================================
// tccw_pkg
// Shared types, codes and helpers for the text console character writer.
// ============================================================================
`default_nettype none

package tccw_pkg;

  // Default geometry and queue depth
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int TAB_STOP_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Attribute register reset value (light grey on black)
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Action codes on the input channel
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_SETCUR = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

  // Nibble masks for the hex escape
  localparam logic [7:0] HEX_HI_MASK = 8'hF0;
  localparam logic [7:0] HEX_LO_MASK = 8'h0F;

  // Classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_TAB,
    OP_CR,
    OP_BACKSPACE,
    OP_ESCAPE,
    OP_SETCUR,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] col;
    logic [7:0] row;
    logic       reject;
  } cmd_t;

  typedef struct packed {
    logic [2:0] written_count;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       rejected;
  } res_t;

  // Lower-case hex digit for a nibble ("0123456789abcdef")
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
  endfunction

endpackage

`default_nettype wire

### design/tccw_ram.sv
// ============================================================================
// tccw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module tccw_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/tccw_front.sv
// ============================================================================
// tccw_front
// Input decoder: turns an input transaction into a classified command.
// ============================================================================
`default_nettype none

module tccw_front #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  wire logic [1:0]      action,
  input  wire logic [7:0]      char_code,
  input  wire logic [7:0]      column,
  input  wire logic [7:0]      row,
  output tccw_pkg::cmd_t       cmd
);

  logic in_range;

  // Cursor request range check, done once here
  assign in_range = ({1'b0, column} < 9'(COLUMNS)) && ({1'b0, row} < 9'(ROWS));

  always_comb begin
    cmd.data   = char_code;
    cmd.col    = column;
    cmd.row    = row;
    cmd.reject = 1'b0;
    cmd.op     = tccw_pkg::OP_READ;
    unique case (action)
      tccw_pkg::ACT_WRITE: begin
        priority if (char_code >= tccw_pkg::CH_PRINT_LO &&
                     char_code <= tccw_pkg::CH_PRINT_HI) begin
          cmd.op = tccw_pkg::OP_PRINT;
        end else if (char_code == tccw_pkg::CH_NEWLINE) begin
          cmd.op = tccw_pkg::OP_NEWLINE;
        end else if (char_code == tccw_pkg::CH_TAB) begin
          cmd.op = tccw_pkg::OP_TAB;
        end else if (char_code == tccw_pkg::CH_CR) begin
          cmd.op = tccw_pkg::OP_CR;
        end else if (char_code == tccw_pkg::CH_BACKSPACE) begin
          cmd.op = tccw_pkg::OP_BACKSPACE;
        end else begin
          cmd.op = tccw_pkg::OP_ESCAPE;
        end
      end
      tccw_pkg::ACT_SETCUR: begin
        cmd.op     = tccw_pkg::OP_SETCUR;
        cmd.reject = ~in_range;
      end
      tccw_pkg::ACT_CLEAR: cmd.op = tccw_pkg::OP_CLEAR;
      tccw_pkg::ACT_READ:  cmd.op = tccw_pkg::OP_READ;
    endcase
  end

endmodule

`default_nettype wire

### design/tccw_fifo.sv
// ============================================================================
// tccw_fifo
// Short command queue between the decoder and the execution engine.
// ============================================================================
`default_nettype none

module tccw_fifo #(
  parameter int DEPTH = tccw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tccw_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output tccw_pkg::cmd_t      head_cmd,
  output logic                not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tccw_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### design/tccw_back.sv
// ============================================================================
// tccw_back
// Execution engine: owns the screen store and cursor, runs cell writes,
// scrolls, clears and reads, and holds the result register.
// ============================================================================
`default_nettype none

module tccw_back #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tccw_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire logic [7:0]     attr,
  output tccw_pkg::res_t      res,
  output logic                res_valid,
  input  wire logic           res_ready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int EMAX  = (COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP;
  localparam int EW    = $clog2(EMAX + 1);
  // Reciprocal of the tab stop: exact quotient for every AW-bit index
  localparam int TK    = AW + $clog2(TAB_STOP);
  localparam int TM    = ((1 << TK) + TAB_STOP - 1) / TAB_STOP;
  localparam int PW    = 2 * AW + 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TABMOD,
    S_TABREM,
    S_EMIT,
    S_SCROLL,
    S_CLEAR,
    S_READ
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  tccw_pkg::op_t   op_r, op_nxt;
  logic [7:0]      data_r, data_nxt;
  logic [EW-1:0]   left_r, left_nxt;
  logic [1:0]      step_r, step_nxt;
  logic [SW-1:0]   sweep_r, sweep_nxt;
  logic [AW-1:0]   quo_r, quo_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  tccw_pkg::res_t  res_r, res_nxt;
  logic            res_valid_r, res_valid_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     mem_rdata;

  logic [AW-1:0]   cur_addr;
  logic            at_last;
  logic            at_home;
  logic [7:0]      emit_ch;
  logic [SW-1:0]   sweep_dec;
  logic [PW-1:0]   tab_prod;

  assign res       = res_r;
  assign res_valid = res_valid_r;

  // Screen store
  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Linear cell address of the cursor
  assign cur_addr  = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign at_last   = (row_r == RW'(ROWS - 1)) && (col_r == CW'(COLUMNS - 1));
  assign at_home   = (row_r == '0) && (col_r == '0);
  assign sweep_dec = sweep_r - SW'(1);
  assign tab_prod  = PW'(cur_addr) * PW'(TM);

  // Character for the next cell write
  always_comb begin
    unique case (op_r)
      tccw_pkg::OP_PRINT:   emit_ch = data_r;
      tccw_pkg::OP_NEWLINE: emit_ch = tccw_pkg::CH_NUL;
      tccw_pkg::OP_ESCAPE: begin
        unique case (step_r)
          2'd0:    emit_ch = tccw_pkg::CH_TILDE;
          2'd1:    emit_ch = tccw_pkg::hex_digit(4'((data_r & tccw_pkg::HEX_HI_MASK) >> 4));
          default: emit_ch = tccw_pkg::hex_digit(4'(data_r & tccw_pkg::HEX_LO_MASK));
        endcase
      end
      default: emit_ch = tccw_pkg::CH_SPACE;
    endcase
  end

  // Next-state logic
  always_comb begin
    logic              fin;
    logic [2:0]        fin_cnt;
    logic              fin_rej;
    logic [7:0]        fin_ch;
    logic [7:0]        fin_attr;
    logic [AW-1:0]     tab_rem;
    logic [EW-1:0]     tab_n;
    logic [CW+6:0]     col_wide;
    logic [RW+4:0]     row_wide;

    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    op_nxt        = op_r;
    data_nxt      = data_r;
    left_nxt      = left_r;
    step_nxt      = step_r;
    sweep_nxt     = sweep_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r & ~res_ready;

    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {attr, emit_ch};
    mem_raddr = cur_addr;

    fin      = 1'b0;
    fin_cnt  = cnt_r;
    fin_rej  = 1'b0;
    fin_ch   = 8'h00;
    fin_attr = 8'h00;
    tab_rem  = '0;
    tab_n    = '0;

    unique case (state_r)
      // Fill sweep: zero after reset, blank cells for a clear
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r[AW-1:0];
        mem_wdata = (state_r == S_INIT) ? 16'h0000 : {attr, tccw_pkg::CH_NUL};
        sweep_nxt = sweep_r + SW'(1);
        if (sweep_r == SW'(CELLS - 1)) begin
          sweep_nxt = '0;
          if (state_r == S_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt = '0;
            row_nxt = '0;
            fin     = 1'b1;
            fin_cnt = 3'd0;
          end
        end
      end

      // Dispatch a queued command once the result register can take it
      S_IDLE: begin
        if (cmd_valid && (!res_valid_r || res_ready)) begin
          cmd_pop  = 1'b1;
          op_nxt   = cmd.op;
          data_nxt = cmd.data;
          step_nxt = '0;
          cnt_nxt  = 3'd0;
          unique case (cmd.op)
            tccw_pkg::OP_PRINT: begin
              left_nxt  = EW'(1);
              cnt_nxt   = 3'd1;
              state_nxt = S_EMIT;
            end
            tccw_pkg::OP_NEWLINE: begin
              left_nxt  = EW'(COLUMNS) - EW'(col_r);
              state_nxt = S_EMIT;
            end
            tccw_pkg::OP_TAB: begin
              state_nxt = S_TABMOD;
            end
            tccw_pkg::OP_ESCAPE: begin
              left_nxt  = EW'(3);
              cnt_nxt   = 3'd3;
              state_nxt = S_EMIT;
            end
            tccw_pkg::OP_CR: begin
              col_nxt = '0;
              fin     = 1'b1;
              fin_cnt = 3'd0;
            end
            tccw_pkg::OP_BACKSPACE: begin
              if (at_home) begin
                fin     = 1'b1;
                fin_cnt = 3'd0;
              end else begin
                // step back; the blank goes here and the cursor stays
                if (col_r == '0) begin
                  col_nxt = CW'(COLUMNS - 1);
                  row_nxt = row_r - RW'(1);
                end else begin
                  col_nxt = col_r - CW'(1);
                end
                left_nxt  = EW'(1);
                state_nxt = S_EMIT;
              end
            end
            tccw_pkg::OP_SETCUR: begin
              if (!cmd.reject) begin
                col_nxt = cmd.col[CW-1:0];
                row_nxt = cmd.row[RW-1:0];
              end
              fin     = 1'b1;
              fin_cnt = 3'd0;
              fin_rej = cmd.reject;
            end
            tccw_pkg::OP_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = S_CLEAR;
            end
            tccw_pkg::OP_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              fin     = 1'b1;
              fin_cnt = 3'd0;
            end
          endcase
        end
      end

      // Read data for the cursor cell arrives in the cycle after dispatch
      S_READ: begin
        fin      = 1'b1;
        fin_cnt  = 3'd0;
        fin_ch   = mem_rdata[7:0];
        fin_attr = mem_rdata[15:8];
      end

      // Cursor index divided by the tab stop, by reciprocal multiply
      S_TABMOD: begin
        quo_nxt   = AW'(tab_prod >> TK);
        state_nxt = S_TABREM;
      end

      // Remainder from the quotient gives the spaces to the next stop
      S_TABREM: begin
        tab_rem   = cur_addr - quo_r * AW'(TAB_STOP);
        tab_n     = EW'(TAB_STOP) - EW'(tab_rem);
        left_nxt  = tab_n;
        cnt_nxt   = (tab_n > EW'(7)) ? 3'd7 : tab_n[2:0];
        state_nxt = S_EMIT;
      end

      // One cell write per cycle; scroll first when at the last cell
      S_EMIT: begin
        if (at_last) begin
          sweep_nxt = '0;
          state_nxt = S_SCROLL;
        end else begin
          mem_we   = 1'b1;
          step_nxt = step_r + 2'd1;
          left_nxt = left_r - EW'(1);
          if (op_r != tccw_pkg::OP_BACKSPACE) begin
            if (col_r == CW'(COLUMNS - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + RW'(1);
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end
          if (left_r == EW'(1)) begin
            fin = 1'b1;
          end
        end
      end

      // Copy each cell up one row, then blank the bottom row
      S_SCROLL: begin
        mem_raddr = AW'(sweep_r) + AW'(COLUMNS);
        mem_waddr = sweep_dec[AW-1:0];
        mem_wdata = (sweep_r <= SW'(CELLS - COLUMNS)) ? mem_rdata
                                                      : {attr, tccw_pkg::CH_NUL};
        mem_we    = (sweep_r != '0);
        sweep_nxt = sweep_r + SW'(1);
        if (sweep_r == SW'(CELLS)) begin
          sweep_nxt = '0;
          row_nxt   = row_r - RW'(1);
          state_nxt = S_EMIT;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Load the result register when a command completes
    col_wide = {7'd0, col_nxt};
    row_wide = {5'd0, row_nxt};
    if (fin) begin
      state_nxt             = S_IDLE;
      res_valid_nxt         = 1'b1;
      res_nxt.written_count = fin_cnt;
      res_nxt.cursor_column = col_wide[6:0];
      res_nxt.cursor_row    = row_wide[4:0];
      res_nxt.cell_char     = fin_ch;
      res_nxt.cell_attr     = fin_attr;
      res_nxt.rejected      = fin_rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      sweep_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sweep_r     <= sweep_nxt;
      res_valid_r <= res_valid_nxt;
      op_r        <= op_nxt;
      data_r      <= data_nxt;
      left_r      <= left_nxt;
      step_r      <= step_nxt;
      quo_r       <= quo_nxt;
      cnt_r       <= cnt_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### design/text_console_char_writer.sv
// ============================================================================
// text_console_char_writer
// Text-mode console: character/attribute screen store with a linear cursor.
// ============================================================================
// Accept to out_valid: cursor set and carriage return finish at dispatch; a read
//   passes the read state; printable, escape, newline, tab and backspace (not at
//   home) write cells one at a time. A clear sweeps all COLUMNS*ROWS cells; a write
//   at the last cell first scrolls (copy sweep). The engine runs one command at a
//   time, QUEUE_DEPTH queued. Reset: synchronous; a clearing pass over all cells
//   zeroes the store, while up to QUEUE_DEPTH commands queue but none executes.
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS     = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tccw_pkg::ROWS_DEF,
  parameter int TAB_STOP    = tccw_pkg::TAB_STOP_DEF,
  parameter int QUEUE_DEPTH = tccw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_char_code,
  input  wire logic [7:0] in_column,
  input  wire logic [7:0] in_row,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_written_count,
  output logic [6:0]      out_cursor_column,
  output logic [4:0]      out_cursor_row,
  output logic [7:0]      out_cell_char,
  output logic [7:0]      out_cell_attr,
  output logic            out_rejected
);

  logic [7:0]     attr_r;
  tccw_pkg::cmd_t dec_cmd;
  tccw_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;
  tccw_pkg::res_t res;

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::ATTR_RESET;
    end else if (cfg_write_en) begin
      attr_r <= cfg_write_data;
    end
  end

  assign in_ready = ~q_full;

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .action    (in_action),
    .char_code (in_char_code),
    .column    (in_column),
    .row       (in_row),
    .cmd       (dec_cmd)
  );

  tccw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid & ~q_full),
    .push_cmd  (dec_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty)
  );

  tccw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .attr      (attr_r),
    .res       (res),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

  assign out_written_count = res.written_count;
  assign out_cursor_column = res.cursor_column;
  assign out_cursor_row    = res.cursor_row;
  assign out_cell_char     = res.cell_char;
  assign out_cell_attr     = res.cell_attr;
  assign out_rejected      = res.rejected;

endmodule

`default_nettype wire

### design/tccw_checker.sv
// ============================================================================
// tccw_checker
// Port-level checks on the console result channel, bound to the top level.
// ============================================================================
`default_nettype none

module tccw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_written_count,
  input wire logic [6:0] out_cursor_column,
  input wire logic [4:0] out_cursor_row,
  input wire logic [7:0] out_cell_char,
  input wire logic [7:0] out_cell_attr,
  input wire logic       out_rejected
);

  // No result is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_written_count) &&
      $stable(out_cursor_column) && $stable(out_cursor_row) &&
      $stable(out_cell_char) && $stable(out_cell_attr) && $stable(out_rejected))
    else $error("stalled result changed");

  // A refused cursor set writes nothing and reads nothing
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |->
      out_written_count == 3'd0 && out_cell_char == 8'h00 && out_cell_attr == 8'h00)
    else $error("rejected transaction carries data");

  // Cell writes never report read data
  a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_written_count != 3'd0 |->
      !out_rejected && out_cell_char == 8'h00 && out_cell_attr == 8'h00)
    else $error("write transaction carries read data");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_written_count (out_written_count),
  .out_cursor_column (out_cursor_column),
  .out_cursor_row    (out_cursor_row),
  .out_cell_char     (out_cell_char),
  .out_cell_attr     (out_cell_attr),
  .out_rejected      (out_rejected)
);

`default_nettype wire
